### design/wsd_pkg.sv
// Shared types and constants of the websocket deframer.
// Holds the result record, the push record and the opcode and action codes.
// No dependencies.
package wsd_pkg;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'ha;

  localparam logic [6:0] LEN_EXT16 = 7'h7e;
  localparam logic [6:0] LEN_EXT64 = 7'h7f;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_ACTION = 1'b1;

  localparam logic [2:0] ACT_TEXT         = 3'd0;
  localparam logic [2:0] ACT_BINARY       = 3'd1;
  localparam logic [2:0] ACT_CLOSE        = 3'd2;
  localparam logic [2:0] ACT_PONG_SEND    = 3'd3;
  localparam logic [2:0] ACT_PONG_IGNORE  = 3'd4;
  localparam logic [2:0] ACT_CLOSE_IGNORE = 3'd5;
  localparam logic [2:0] ACT_PROTO_ERROR  = 3'd6;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [3:0] msg_opcode;
    logic       final_frame;
    logic [2:0] action;
    logic       last;
  } wsd_result_t;

  // Up to two results leave the parser for one received byte.
  typedef struct packed {
    logic [1:0]  cnt;
    wsd_result_t first;
    wsd_result_t second;
  } wsd_push_t;

endpackage

### design/wsd_in_if.sv
// Receive channel of the websocket deframer: one stream byte per transfer.
// No dependencies.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### design/wsd_out_if.sv
// Result channel of the websocket deframer: one payload byte or action per transfer.
// No dependencies.
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [3:0] msg_opcode;
  logic       final_frame;
  logic [2:0] action;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output msg_opcode,
                  output final_frame, output action, output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input msg_opcode,
                input final_frame, input action, input last, output ready);
endinterface

### design/wsd_parser.sv
// Frame parser: header, extended length, mask key, payload unmasking and the action of each final frame.
// Depends on wsd_pkg for the result record and the opcode and action codes.
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] rx_byte_i,
  output wsd_push_t  push_o
);

  localparam logic [2:0] PH_HDR1    = 3'd0;
  localparam logic [2:0] PH_HDR2    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]             phase_q, phase_d;
  logic                   fin_q, fin_d;
  logic                   masked_q, masked_d;
  logic [3:0]             op_q, op_d;
  logic [3:0]             held_q, held_d;
  logic [3:0]             lbl_q, lbl_d;
  logic [2:0]             kbl_q, kbl_d;
  logic [LENGTH_BITS-1:0] pl_q, pl_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             mpos_q, mpos_d;
  logic [1:0]             mc_q, mc_d;
  logic                   stop_q, stop_d;

  logic        do_after, do_start, do_end;
  logic [1:0]  key_sel;
  logic [7:0]  unmasked;
  logic [2:0]  act;
  wsd_result_t res0, res1;
  logic [1:0]  cnt;

  assign key_sel  = 2'd3 - mpos_q;
  assign unmasked = masked_q ? (rx_byte_i ^ key_q[{key_sel, 3'b000} +: 8]) : rx_byte_i;

  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    op_d     = op_q;
    held_d   = held_q;
    lbl_d    = lbl_q;
    kbl_d    = kbl_q;
    pl_d     = pl_q;
    key_d    = key_q;
    mpos_d   = mpos_q;
    mc_d     = mc_q;
    stop_d   = stop_q;
    do_after = 1'b0;
    do_start = 1'b0;
    do_end   = 1'b0;
    act      = ACT_PROTO_ERROR;
    cnt      = 2'd0;
    res0     = '0;
    res1     = '0;

    if (fire_i && !stop_q) begin
      unique case (phase_q)
        PH_HDR1: begin
          fin_d   = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PH_HDR2;
        end
        PH_HDR2: begin
          masked_d = rx_byte_i[7];
          pl_d     = '0;
          if (rx_byte_i[6:0] == LEN_EXT16) begin
            lbl_d   = 4'd2;
            phase_d = PH_EXTLEN;
          end else if (rx_byte_i[6:0] == LEN_EXT64) begin
            lbl_d   = 4'd8;
            phase_d = PH_EXTLEN;
          end else begin
            pl_d     = {{(LENGTH_BITS-7){1'b0}}, rx_byte_i[6:0]};
            do_after = 1'b1;
          end
        end
        PH_EXTLEN: begin
          // The length saturates once a further byte would shift bits out.
          if (|pl_q[LENGTH_BITS-1 -: 8]) begin
            pl_d = '1;
          end else begin
            pl_d = {pl_q[LENGTH_BITS-9:0], rx_byte_i};
          end
          lbl_d = lbl_q - 4'd1;
          if (lbl_d == 4'd0) begin
            do_after = 1'b1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          kbl_d = kbl_q - 3'd1;
          if (kbl_d == 3'd0) begin
            do_start = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          mpos_d = mpos_q + 2'd1;
          if (mc_q != 2'd3) begin
            mc_d = mc_q + 2'd1;
          end
          res0.kind         = KIND_BYTE;
          res0.payload_byte = unmasked;
          res0.msg_opcode   = op_q;
          res0.final_frame  = fin_q;
          res0.action       = ACT_TEXT;
          cnt               = 2'd1;
          if (pl_q != '0) begin
            pl_d = pl_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
          end
          if (pl_d == '0) begin
            do_end = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HDR1;
        end
      endcase

      if (do_after) begin
        if (masked_d) begin
          kbl_d   = 3'd4;
          phase_d = PH_KEY;
        end else begin
          do_start = 1'b1;
        end
      end

      if (do_start) begin
        // A non-final data frame opens a fragmented message; a final
        // continuation frame takes the held opcode over.
        if (!fin_d && op_d != OP_CONT && !op_d[3] && held_q == OP_CONT) begin
          held_d = op_d;
        end else if (fin_d && op_d == OP_CONT && held_q != OP_CONT && !held_q[3]) begin
          op_d   = held_q;
          held_d = OP_CONT;
        end
        mpos_d = 2'd0;
        if (pl_d == '0) begin
          do_end = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end

      if (do_end) begin
        phase_d = PH_HDR1;
        if (fin_d) begin
          unique case (op_d)
            OP_TEXT:   act = ACT_TEXT;
            OP_BINARY: act = ACT_BINARY;
            OP_CLOSE:  act = (mc_d == 2'd2) ? ACT_CLOSE : ACT_CLOSE_IGNORE;
            OP_PING:   act = ACT_PONG_SEND;
            OP_PONG:   act = ACT_PONG_IGNORE;
            default:   act = ACT_PROTO_ERROR;
          endcase
          res1.kind         = KIND_ACTION;
          res1.payload_byte = 8'h00;
          res1.msg_opcode   = op_d;
          res1.final_frame  = fin_d;
          res1.action       = act;
          mc_d              = 2'd0;
          if (act == ACT_CLOSE || act == ACT_PROTO_ERROR) begin
            stop_d = 1'b1;
          end
          if (cnt == 2'd0) begin
            res0 = res1;
          end
          cnt = cnt + 2'd1;
        end
      end
    end

    res0.last = (cnt == 2'd1);
    res1.last = 1'b1;
  end

  assign push_o.cnt    = cnt;
  assign push_o.first  = res0;
  assign push_o.second = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR1;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      op_q     <= OP_CONT;
      held_q   <= OP_CONT;
      lbl_q    <= 4'd0;
      kbl_q    <= 3'd0;
      pl_q     <= '0;
      key_q    <= 32'd0;
      mpos_q   <= 2'd0;
      mc_q     <= 2'd0;
      stop_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      op_q     <= op_d;
      held_q   <= held_d;
      lbl_q    <= lbl_d;
      kbl_q    <= kbl_d;
      pl_q     <= pl_d;
      key_q    <= key_d;
      mpos_q   <= mpos_d;
      mc_q     <= mc_d;
      stop_q   <= stop_d;
    end
  end

endmodule

### design/wsd_outbuf.sv
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on wsd_pkg for the result and push records.
module wsd_outbuf
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wsd_push_t   push_i,
  input  logic        pop_i,
  output logic        room_o,
  output logic        valid_o,
  output wsd_result_t head_o
);

  wsd_result_t mem_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  count_q, count_d;
  logic        pop;

  assign pop     = pop_i && (count_q != 3'd0);
  assign count_d = count_q + {1'b0, push_i.cnt} - {2'b00, pop};
  assign room_o  = (count_q <= 3'd2);
  assign valid_o = (count_q != 3'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 2'd0;
      rd_q    <= 2'd0;
      count_q <= 3'd0;
    end else begin
      wr_q    <= wr_q + push_i.cnt;
      rd_q    <= rd_q + {1'b0, pop};
      count_q <= count_d;
    end
  end

endmodule

### design/websocket_deframer_core.sv
// Websocket receive deframer, top level; uses wsd_pkg, wsd_parser, wsd_outbuf, both channels.
// Each result is queued with the byte transfer that caused it and offered on tx_o in turn.
// Throughput: one byte per cycle while rx_i.ready is high; a byte that ends a frame with a
// payload byte and an action yields two results that leave in order via the four-entry queue.
// rx_i.ready drops while fewer than two queue entries are free.
// Reset (asynchronous, active low) clears the parser state and empties the queue at once.
module websocket_deframer_core
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  wsd_in_if.sink   rx_i,
  wsd_out_if.source tx_o
);

  // The parser keeps all frame state and works each accepted byte in the
  // same cycle; its results land in the queue, which parts the two sides.
  wsd_push_t   push;
  logic        room;
  logic        fire;
  wsd_result_t head;

  // A byte is only taken while the queue can hold the worst case of two results.
  assign rx_i.ready = room;
  assign fire       = rx_i.valid && room;

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .rx_byte_i(rx_i.rx_byte),
    .push_o   (push)
  );

  wsd_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (tx_o.ready),
    .room_o (room),
    .valid_o(tx_o.valid),
    .head_o (head)
  );

  assign tx_o.kind         = head.kind;
  assign tx_o.payload_byte = head.payload_byte;
  assign tx_o.msg_opcode   = head.msg_opcode;
  assign tx_o.final_frame  = head.final_frame;
  assign tx_o.action       = head.action;
  assign tx_o.last         = head.last;

  // The parser may only produce results for a byte that was actually transferred.
  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |-> push.cnt == 2'd0)
    else $error("results pushed without an accepted byte");

  // At most two results per byte.
  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != 2'd3)
    else $error("more than two results for one byte");

  // A pair is always a payload byte followed by the closing action.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> push.first.kind == KIND_BYTE && !push.first.last &&
                         push.second.kind == KIND_ACTION && push.second.last)
    else $error("result pair out of order");

  // A stalled result must not change under the sink.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_o.valid && !tx_o.ready |=> tx_o.valid && $stable(head))
    else $error("queued result changed while stalled");

endmodule
